// File: rtl/pngu_pkg.sv
package pngu_pkg;

  typedef enum logic [3:0] {
    FMT_G1   = 4'd0,
    FMT_G2   = 4'd1,
    FMT_G4   = 4'd2,
    FMT_G8   = 4'd3,
    FMT_GA   = 4'd4,
    FMT_I1   = 4'd5,
    FMT_I2   = 4'd6,
    FMT_I4   = 4'd7,
    FMT_I8   = 4'd8,
    FMT_RGB  = 4'd9,
    FMT_RGBA = 4'd10
  } fmt_t;

  typedef enum logic [2:0] {
    REG_PIXEL_FORMAT = 3'd0,
    REG_LINE_WIDTH   = 3'd1,
    REG_KEY_ENABLE   = 3'd2,
    REG_KEY_GRAY     = 3'd3,
    REG_KEY_RED      = 3'd4,
    REG_KEY_GREEN    = 3'd5,
    REG_KEY_BLUE     = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_idx_t;

  localparam int ADDR_W = 5;

  typedef struct packed {
    logic [3:0]  pixel_format;
    logic [15:0] line_width;
    logic        key_enable;
    logic [7:0]  key_gray;
    logic [7:0]  key_red;
    logic [7:0]  key_green;
    logic [7:0]  key_blue;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       pal;
    logic       oob;
    logic       last;
    logic       line_end;
  } pix_t;

endpackage

// File: rtl/pngu_regs.sv
module pngu_regs
  import pngu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format <= FMT_G8;
      cfg.line_width   <= 16'd1;
      cfg.key_enable   <= 1'b0;
      cfg.key_gray     <= 8'd0;
      cfg.key_red      <= 8'd0;
      cfg.key_green    <= 8'd0;
      cfg.key_blue     <= 8'd0;
    end else if (wr) begin
      case (idx)
        REG_PIXEL_FORMAT: cfg.pixel_format <= pwdata[3:0];
        REG_LINE_WIDTH:   cfg.line_width   <= pwdata[15:0];
        REG_KEY_ENABLE:   cfg.key_enable   <= pwdata[0];
        REG_KEY_GRAY:     cfg.key_gray     <= pwdata[7:0];
        REG_KEY_RED:      cfg.key_red      <= pwdata[7:0];
        REG_KEY_GREEN:    cfg.key_green    <= pwdata[7:0];
        REG_KEY_BLUE:     cfg.key_blue     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PIXEL_FORMAT: prdata = {28'd0, cfg.pixel_format};
      REG_LINE_WIDTH:   prdata = {16'd0, cfg.line_width};
      REG_KEY_ENABLE:   prdata = {31'd0, cfg.key_enable};
      REG_KEY_GRAY:     prdata = {24'd0, cfg.key_gray};
      REG_KEY_RED:      prdata = {24'd0, cfg.key_red};
      REG_KEY_GREEN:    prdata = {24'd0, cfg.key_green};
      REG_KEY_BLUE:     prdata = {24'd0, cfg.key_blue};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/pngu_palette.sv
module pngu_palette #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        we,
  input  logic [7:0]  waddr,
  input  logic [31:0] wdata,
  input  logic        re,
  input  logic [7:0]  raddr,
  output logic [31:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    // read data holds while the output stage is stalled
    if (re) begin
      rdata <= mem[raddr[AW-1:0]];
    end
  end

endmodule

// File: rtl/pngu_unpack.sv
module pngu_unpack
  import pngu_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  sample_first,
  input  logic [7:0]  sample_second,
  input  logic [7:0]  sample_third,
  input  logic [7:0]  sample_fourth,
  input  logic [7:0]  palette_slot,
  input  logic [31:0] palette_color,
  input  logic        pix_ready,
  output logic        pix_fire,
  output pix_t        pix,
  output logic [7:0]  rd_addr,
  output logic        wr_en,
  output logic [7:0]  wr_addr,
  output logic [31:0] wr_data
);

  logic        a_valid;
  logic        a_kind;
  logic [7:0]  a_s1;
  logic [7:0]  a_s2;
  logic [7:0]  a_s3;
  logic [7:0]  a_s4;
  logic [7:0]  a_slot;
  logic [31:0] a_color;
  logic [2:0]  a_idx;
  logic [15:0] column;

  fmt_t        fmt;
  logic [3:0]  fmt_off;
  logic [1:0]  sel;
  logic [4:0]  amt;
  logic [7:0]  shifted;
  logic [7:0]  v;
  logic [7:0]  gray;
  logic        packed_fmt;
  logic        last_sample;
  logic        is_pix;
  logic [16:0] col_sum;
  logic        col_end;
  logic        done;
  logic        gray_key;

  assign fmt     = fmt_t'(cfg.pixel_format);
  assign fmt_off = cfg.pixel_format - 4'(FMT_I1);
  assign sel     = (cfg.pixel_format <= 4'(FMT_G4)) ? cfg.pixel_format[1:0] : fmt_off[1:0];
  assign amt     = {2'b00, a_idx} << sel;
  assign shifted = a_s1 << amt;
  assign last_sample = (a_idx == (3'd7 >> sel));

  always_comb begin
    case (sel)
      2'd0: begin
        v    = {7'd0, shifted[7]};
        gray = {8{shifted[7]}};
      end
      2'd1: begin
        v    = {6'd0, shifted[7:6]};
        gray = {4{shifted[7:6]}};
      end
      default: begin
        v    = {4'd0, shifted[7:4]};
        gray = {2{shifted[7:4]}};
      end
    endcase
  end

  assign col_sum  = {1'b0, column} + 17'd1;
  assign col_end  = col_sum >= {1'b0, cfg.line_width};
  assign gray_key = cfg.key_enable;

  always_comb begin
    pix        = '0;
    rd_addr    = a_s1;
    is_pix     = 1'b1;
    packed_fmt = 1'b0;
    case (fmt)
      FMT_G1, FMT_G2, FMT_G4: begin
        packed_fmt = 1'b1;
        pix.red    = gray;
        pix.green  = gray;
        pix.blue   = gray;
        pix.alpha  = (gray_key && gray == cfg.key_gray) ? 8'd0 : 8'd255;
      end
      FMT_G8: begin
        pix.red   = a_s1;
        pix.green = a_s1;
        pix.blue  = a_s1;
        pix.alpha = (gray_key && a_s1 == cfg.key_gray) ? 8'd0 : 8'd255;
      end
      FMT_GA: begin
        pix.red   = a_s1;
        pix.green = a_s1;
        pix.blue  = a_s1;
        pix.alpha = a_s2;
      end
      FMT_I1, FMT_I2, FMT_I4: begin
        packed_fmt = 1'b1;
        pix.pal    = 1'b1;
        rd_addr    = v;
      end
      FMT_I8: begin
        pix.pal = 1'b1;
      end
      FMT_RGB: begin
        pix.red   = a_s1;
        pix.green = a_s2;
        pix.blue  = a_s3;
        pix.alpha = (cfg.key_enable && a_s1 == cfg.key_red && a_s2 == cfg.key_green &&
                     a_s3 == cfg.key_blue) ? 8'd0 : 8'd255;
      end
      FMT_RGBA: begin
        pix.red   = a_s1;
        pix.green = a_s2;
        pix.blue  = a_s3;
        pix.alpha = a_s4;
      end
      default: is_pix = 1'b0;
    endcase
    // index beyond the palette reads as all zero
    pix.oob      = pix.pal && ({1'b0, rd_addr} >= 9'(PALETTE_DEPTH));
    pix.line_end = col_end;
    pix.last     = col_end || !packed_fmt || last_sample;
  end

  assign pix_fire = a_valid && !a_kind && is_pix && pix_ready;
  assign done     = a_valid && (a_kind || !is_pix || (pix_ready && pix.last));
  assign in_ready = !a_valid || done;

  assign wr_en   = a_valid && a_kind && ({1'b0, a_slot} < 9'(PALETTE_DEPTH));
  assign wr_addr = a_slot;
  assign wr_data = a_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      column  <= 16'd0;
    end else begin
      if (in_valid && in_ready) begin
        a_valid <= 1'b1;
      end else if (done) begin
        a_valid <= 1'b0;
      end
      if (pix_fire) begin
        column <= col_end ? 16'd0 : col_sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_kind  <= kind;
      a_s1    <= sample_first;
      a_s2    <= sample_second;
      a_s3    <= sample_third;
      a_s4    <= sample_fourth;
      a_slot  <= palette_slot;
      a_color <= palette_color;
      a_idx   <= 3'd0;
    end else if (pix_fire) begin
      a_idx <= a_idx + 3'd1;
    end
  end

endmodule

// File: rtl/pngu_out.sv
module pngu_out
  import pngu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pix_fire,
  input  pix_t        pix_in,
  output logic        pix_ready,
  input  logic [31:0] rdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic        last_of_item,
  output logic        line_end
);

  pix_t pix;

  assign pix_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_ready) begin
      out_valid <= pix_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_ready && pix_fire) begin
      pix <= pix_in;
    end
  end

  always_comb begin
    if (pix.pal) begin
      if (pix.oob) begin
        red   = 8'd0;
        green = 8'd0;
        blue  = 8'd0;
        alpha = 8'd0;
      end else begin
        red   = rdata[31:24];
        green = rdata[23:16];
        blue  = rdata[15:8];
        alpha = rdata[7:0];
      end
    end else begin
      red   = pix.red;
      green = pix.green;
      blue  = pix.blue;
      alpha = pix.alpha;
    end
  end

  assign last_of_item = pix.last;
  assign line_end     = pix.line_end;

endmodule

// File: rtl/png_pixel_unpack_rgba8.sv
// the first pixel of an item passes from the input stage register to the output register, which a stall can hold
// throughput: one item per cycle for palette writes, and for single-pixel formats while the output
// is not stalled; packed gray and index bytes likewise give one pixel per cycle, up to 8 per byte (8/bits)
// while not stalled, the unpack stage issues one palette read per cycle on the single read port
// reset loads the register defaults (8-bit gray, width 1, key off), clears column
// and valid flags; palette is undefined until written
module png_pixel_unpack_rgba8
  import pngu_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [7:0]        sample_first,
  input  logic [7:0]        sample_second,
  input  logic [7:0]        sample_third,
  input  logic [7:0]        sample_fourth,
  input  logic [7:0]        palette_slot,
  input  logic [31:0]       palette_color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [7:0]        alpha,
  output logic              last_of_item,
  output logic              line_end
);

  cfg_t        cfg;
  pix_t        pix;
  logic        pix_fire;
  logic        pix_ready;
  logic [7:0]  rd_addr;
  logic [31:0] rdata;
  logic        wr_en;
  logic [7:0]  wr_addr;
  logic [31:0] wr_data;

  pngu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pngu_unpack #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_unpack (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .sample_first  (sample_first),
    .sample_second (sample_second),
    .sample_third  (sample_third),
    .sample_fourth (sample_fourth),
    .palette_slot  (palette_slot),
    .palette_color (palette_color),
    .pix_ready     (pix_ready),
    .pix_fire      (pix_fire),
    .pix           (pix),
    .rd_addr       (rd_addr),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  pngu_palette #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (pix_fire && pix_ready),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  pngu_out u_out (
    .clk          (clk),
    .rst          (rst),
    .pix_fire     (pix_fire),
    .pix_in       (pix),
    .pix_ready    (pix_ready),
    .rdata        (rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .last_of_item (last_of_item),
    .line_end     (line_end)
  );

endmodule

// File: rtl/pngu_checker.sv
module pngu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] alpha,
  input logic       last_of_item,
  input logic       line_end
);

  // a stalled pixel keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green) &&
      $stable(blue) && $stable(alpha) && $stable(last_of_item) && $stable(line_end))
    else $error("output changed while stalled");

  // a line end drops the rest of a packed byte, so it always closes the transaction
  a_line_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> last_of_item)
    else $error("line end without last_of_item");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind png_pixel_unpack_rgba8 pngu_checker u_chk (.*);

// File: tb/tb_top.sv
module tb_top
  import pngu_pkg::*;
;

  localparam int RANDOM_ITEMS = 460;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [3:0] FMT_SPARE_LO = 4'd11;
  localparam logic [3:0] FMT_SPARE_HI = 4'd15;

  typedef struct packed {
    logic        kind;
    logic [7:0]  s1;
    logic [7:0]  s2;
    logic [7:0]  s3;
    logic [7:0]  s4;
    logic [7:0]  slot;
    logic [31:0] color;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic       line_end;
  } px_t;

  typedef struct packed {
    logic        is_cfg;
    reg_idx_t    ridx;
    logic [31:0] rval;
    item_t       it;
    logic        typed;
    px_t         want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [7:0]  sample_first = '0;
  logic [7:0]  sample_second = '0;
  logic [7:0]  sample_third = '0;
  logic [7:0]  sample_fourth = '0;
  logic [7:0]  palette_slot = '0;
  logic [31:0] palette_color = '0;

  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_of_item;
  logic       line_end;

  png_pixel_unpack_rgba8 dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
    .sample_first(sample_first), .sample_second(sample_second),
    .sample_third(sample_third), .sample_fourth(sample_fourth),
    .palette_slot(palette_slot), .palette_color(palette_color),
    .out_valid(out_valid), .out_ready(out_ready),
    .red(red), .green(green), .blue(blue), .alpha(alpha),
    .last_of_item(last_of_item), .line_end(line_end)
  );

  always #5 clk = ~clk;

  // shadow of the block's registers and state
  logic [3:0]  cur_fmt = FMT_G8;
  logic [15:0] cur_width = 16'd1;
  logic        key_on = 1'b0;
  logic [7:0]  key_g = '0;
  logic [7:0]  key_r = '0;
  logic [7:0]  key_gr = '0;
  logic [7:0]  key_b = '0;
  logic [15:0] col_count = '0;
  logic [31:0] clut [256];
  bit          clut_valid [256];

  px_t pending_pixels [$];
  px_t unpack_buf [$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  int  idle_cycles = 0;
  int  stall_left = 0;

  function automatic logic [7:0] key_alpha(input logic [7:0] c);
    return (key_on && c == key_g) ? 8'h00 : 8'hFF;
  endfunction

  // pushes one pixel and steps the column; returns 1 when the line is done
  function automatic logic emit(input logic [7:0] r, g, b, a);
    logic [16:0] next;
    px_t p;
    next = {1'b0, col_count} + 17'd1;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.alpha = a;
    p.last = 1'b0;
    p.line_end = (next >= {1'b0, cur_width});
    col_count = p.line_end ? 16'd0 : next[15:0];
    unpack_buf.push_back(p);
    return p.line_end;
  endfunction

  function automatic void unpack_item(input item_t it);
    int f, bits, scale, i;
    logic [7:0] v, r;
    logic [31:0] w;
    logic done;
    f = cur_fmt;
    if (it.kind) begin
      clut[it.slot] = it.color;
      clut_valid[it.slot] = 1'b1;
      return;
    end
    case (cur_fmt)
      FMT_G1, FMT_G2, FMT_G4, FMT_I1, FMT_I2, FMT_I4: begin
        bits = (f <= FMT_G4) ? (1 << f) : (1 << (f - FMT_I1));
        scale = (bits == 1) ? 255 : (bits == 2) ? 85 : 17;
        done = 1'b0;
        for (i = 0; i < 8 / bits && !done; i++) begin
          v = 8'((it.s1 >> (8 - bits * (i + 1))) & ((1 << bits) - 1));
          if (f <= FMT_G4) begin
            r = 8'(v * scale);
            done = emit(r, r, r, key_alpha(r));
          end else begin
            w = clut[v];
            done = emit(w[31:24], w[23:16], w[15:8], w[7:0]);
          end
        end
      end
      FMT_G8: void'(emit(it.s1, it.s1, it.s1, key_alpha(it.s1)));
      FMT_GA: void'(emit(it.s1, it.s1, it.s1, it.s2));
      FMT_I8: begin
        w = clut[it.s1];
        void'(emit(w[31:24], w[23:16], w[15:8], w[7:0]));
      end
      FMT_RGB: begin
        r = (key_on && it.s1 == key_r && it.s2 == key_gr && it.s3 == key_b) ? 8'h00 : 8'hFF;
        void'(emit(it.s1, it.s2, it.s3, r));
      end
      FMT_RGBA: void'(emit(it.s1, it.s2, it.s3, it.s4));
      default: ;
    endcase
    if (unpack_buf.size() > 0) unpack_buf[$].last = 1'b1;
  endfunction

  function automatic void apply_reg(input reg_idx_t ri, input logic [31:0] v);
    case (ri)
      REG_PIXEL_FORMAT: cur_fmt = v[3:0];
      REG_LINE_WIDTH:   cur_width = v[15:0];
      REG_KEY_ENABLE:   key_on = v[0];
      REG_KEY_GRAY:     key_g = v[7:0];
      REG_KEY_RED:      key_r = v[7:0];
      REG_KEY_GREEN:    key_gr = v[7:0];
      REG_KEY_BLUE:     key_b = v[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] reg_mask(input reg_idx_t ri);
    case (ri)
      REG_PIXEL_FORMAT: return 32'hF;
      REG_LINE_WIDTH:   return 32'hFFFF;
      REG_KEY_ENABLE:   return 32'h1;
      default:          return 32'hFF;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic item_t palette_write(input logic [7:0] slot, input logic [31:0] color);
    item_t it;
    it.kind = 1'b1;
    it.s1 = 8'($urandom);
    it.s2 = 8'($urandom);
    it.s3 = 8'($urandom);
    it.s4 = 8'($urandom);
    it.slot = slot;
    it.color = color;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.kind = ($urandom_range(0, 99) < 8);
    it.s1 = 8'($urandom);
    it.s2 = 8'($urandom);
    it.s3 = 8'($urandom);
    it.s4 = 8'($urandom);
    it.slot = 8'($urandom);
    it.color = $urandom;
    // hit the transparency key now and then
    if (key_on && $urandom_range(0, 3) == 0) begin
      if (cur_fmt == FMT_G8) begin
        it.s1 = key_g;
      end else if (cur_fmt == FMT_RGB) begin
        it.s1 = key_r;
        it.s2 = key_gr;
        it.s3 = key_b;
      end
    end
    return it;
  endfunction

  function automatic dir_row_t pix_row(input logic [7:0] s1, s2, s3, s4);
    dir_row_t row;
    row = '0;
    row.ridx = REG_UNUSED;
    row.it.s1 = s1;
    row.it.s2 = s2;
    row.it.s3 = s3;
    row.it.s4 = s4;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input reg_idx_t ri, input logic [31:0] v);
    dir_row_t row;
    row = pix_row(8'h00, 8'h00, 8'h00, 8'h00);
    row.is_cfg = 1'b1;
    row.ridx = ri;
    row.rval = v;
    return row;
  endfunction

  function automatic dir_row_t pal_row(input logic [7:0] slot, input logic [31:0] color);
    dir_row_t row;
    row = pix_row(8'h00, 8'h00, 8'h00, 8'h00);
    row.it = palette_write(slot, color);
    return row;
  endfunction

  // single pixel whose value is plain from the current settings
  function automatic dir_row_t known_row(input logic [7:0] s1, r, g, b, a,
                                         input logic le);
    dir_row_t row;
    row = pix_row(s1, 8'h00, 8'h00, 8'h00);
    row.typed = 1'b1;
    row.want = {r, g, b, a, 1'b1, le};
    return row;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input item_t it, input logic typed, input px_t want,
                           output int n_px);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= it.kind;
    sample_first <= it.s1;
    sample_second <= it.s2;
    sample_third <= it.s3;
    sample_fourth <= it.s4;
    palette_slot <= it.slot;
    palette_color <= it.color;
    do @(posedge clk); while (!in_ready);
    unpack_item(it);
    n_px = unpack_buf.size();
    if (typed) pending_pixels.push_back(want);
    else foreach (unpack_buf[i]) pending_pixels.push_back(unpack_buf[i]);
    unpack_buf.delete();
  endtask

  // write, then read back in the next transfer
  task automatic write_reg(input reg_idx_t ri, input logic [31:0] v);
    logic [31:0] got;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(ri));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    apply_reg(ri, v);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if ((got & reg_mask(ri)) !== (v & reg_mask(ri))) begin
      $error("readback of %s: expected %0h, got %0h", ri.name(), v & reg_mask(ri), got);
      mismatches++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: check each pixel transaction, stall at random
  always @(posedge clk) begin : pixel_sink
    px_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel with nothing pending: %0h %0h %0h %0h", red, green, blue, alpha);
        mismatches++;
      end else begin
        w = pending_pixels.pop_front();
        check_field("red", w.red, red);
        check_field("green", w.green, green);
        check_field("blue", w.blue, blue);
        check_field("alpha", w.alpha, alpha);
        check_field("last_of_item", {7'd0, w.last}, {7'd0, last_of_item});
        check_field("line_end", {7'd0, w.line_end}, {7'd0, line_end});
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 4) : $urandom_range(20, 60);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    item_t it;
    px_t none;
    int np, counted, n, bits, idx, i;
    none = '0;
    counted = 0;

    // after reset: G8, width 1, key off
    rows.push_back(known_row(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1));
    rows.push_back(known_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    rows.push_back(cfg_row(REG_KEY_ENABLE, 32'd1));
    rows.push_back(known_row(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
    // zero width: first sample ends the line, the rest of the byte is dropped
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_G1));
    rows.push_back(cfg_row(REG_LINE_WIDTH, 32'd0));
    rows.push_back(known_row(8'hA5, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    rows.push_back(cfg_row(REG_LINE_WIDTH, 32'd8));
    rows.push_back(pix_row(8'h5A, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_LINE_WIDTH, 32'd3));
    rows.push_back(pix_row(8'hFF, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_KEY_GRAY, 32'd85));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_G2));
    rows.push_back(pix_row(8'hE4, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_G4));
    rows.push_back(cfg_row(REG_KEY_GRAY, 32'd255));
    rows.push_back(pix_row(8'hF0, 8'h00, 8'h00, 8'h00));
    // gray-alpha ignores the key
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_GA));
    rows.push_back(pix_row(8'hFF, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_LINE_WIDTH, 32'd100));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_RGB));
    rows.push_back(cfg_row(REG_KEY_RED, 32'h12));
    rows.push_back(cfg_row(REG_KEY_GREEN, 32'h34));
    rows.push_back(cfg_row(REG_KEY_BLUE, 32'h56));
    rows.push_back(pix_row(8'h12, 8'h34, 8'h56, 8'h00));
    rows.push_back(pix_row(8'h12, 8'h34, 8'h57, 8'h00));
    rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // width lowered below the column mid-line
    rows.push_back(cfg_row(REG_LINE_WIDTH, 32'd2));
    rows.push_back(pix_row(8'h01, 8'h02, 8'h03, 8'h04));
    rows.push_back(cfg_row(REG_KEY_ENABLE, 32'd0));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_RGBA));
    rows.push_back(pix_row(8'h12, 8'h34, 8'h56, 8'h78));
    rows.push_back(pal_row(8'd0, 32'h11223344));
    rows.push_back(pal_row(8'd1, 32'hFFFFFFFF));
    rows.push_back(pal_row(8'd2, 32'h00000000));
    rows.push_back(pal_row(8'd3, 32'hA5C3E1F0));
    rows.push_back(pal_row(8'd255, 32'h80402010));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_I1));
    rows.push_back(pix_row(8'h69, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_I2));
    rows.push_back(pix_row(8'h1B, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_I4));
    rows.push_back(pix_row(8'h30, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_I8));
    rows.push_back(pix_row(8'hFF, 8'h00, 8'h00, 8'h00));
    // unused formats drop the item
    rows.push_back(cfg_row(REG_LINE_WIDTH, 32'd65535));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_SPARE_LO));
    rows.push_back(pix_row(8'h00, 8'h00, 8'h00, 8'h00));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_SPARE_HI));
    rows.push_back(pix_row(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    rows.push_back(cfg_row(REG_PIXEL_FORMAT, FMT_G8));
    rows.push_back(pix_row(8'h7F, 8'h00, 8'h00, 8'h00));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        wait_idle();
        write_reg(rows[k].ridx, rows[k].rval);
      end else begin
        send_item(rows[k].it, rows[k].typed, rows[k].want, np);
      end
    end

    while (counted < RANDOM_ITEMS) begin
      wait_idle();
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 6)
        write_reg(REG_PIXEL_FORMAT, $urandom_range(FMT_SPARE_LO, FMT_SPARE_HI));
      else
        write_reg(REG_PIXEL_FORMAT, $urandom_range(FMT_G1, FMT_RGBA));
      n = $urandom_range(0, 99);
      if (n < 8)       write_reg(REG_LINE_WIDTH, 32'd0);
      else if (n < 12) write_reg(REG_LINE_WIDTH, 32'd65535);
      else if (n < 20) write_reg(REG_LINE_WIDTH, $urandom_range(1, 65535));
      else             write_reg(REG_LINE_WIDTH, $urandom_range(1, 12));
      write_reg(REG_KEY_ENABLE, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) write_reg(REG_KEY_GRAY, 17 * $urandom_range(0, 15));
      else                      write_reg(REG_KEY_GRAY, pick_byte());
      write_reg(REG_KEY_RED, pick_byte());
      write_reg(REG_KEY_GREEN, pick_byte());
      write_reg(REG_KEY_BLUE, pick_byte());

      repeat ($urandom_range(8, 40)) begin
        if ($urandom_range(0, 99) < 3) wait_idle();
        it = random_item();
        // never index a palette entry that has not been loaded
        if (!it.kind && cur_fmt >= FMT_I1 && cur_fmt <= FMT_I8) begin
          bits = 1 << (int'(cur_fmt) - FMT_I1);
          for (i = 0; i < 8 / bits; i++) begin
            idx = (it.s1 >> (8 - bits * (i + 1))) & ((1 << bits) - 1);
            if (!clut_valid[idx]) begin
              send_item(palette_write(8'(idx), $urandom), 1'b0, none, np);
              counted++;
            end
          end
        end
        send_item(it, 1'b0, none, np);
        if (it.kind || np > 0) counted++;
      end
    end

    calm = 1'b0;
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/pngu_pkg.sv
rtl/pngu_regs.sv
rtl/pngu_palette.sv
rtl/pngu_unpack.sv
rtl/pngu_out.sv
rtl/png_pixel_unpack_rgba8.sv
rtl/pngu_checker.sv
tb/tb_top.sv
